// ----- hdl/ebtc_pkg.sv -----
// ----------------------------------------------------------------------------
// ebtc_pkg
// Shared types, constants and helpers of the exact binary64 threshold check.
// ----------------------------------------------------------------------------
package ebtc_pkg;

  localparam int FRAC_BITS   = 52;
  localparam int SIG_BITS    = 53;
  localparam int EXP_W       = 12;
  localparam int EXP_FIELD_W = 11;
  localparam int EXP_BIAS    = 1075;
  localparam int SUBNORM_EXP = -1074;
  localparam int HALF_W      = 27;
  localparam int PROD_W      = 2 * SIG_BITS;
  // window lsb sits this many bits below the threshold's lsb
  localparam int WIN_OFS     = 220;
  localparam int WIN_W       = WIN_OFS + SIG_BITS + 3;
  localparam int WIN_TOP     = PROD_W + WIN_W;
  localparam int SHIFT_W     = WIN_TOP + PROD_W;
  localparam int SUM_W       = WIN_W + 2;
  localparam int AMT_W       = 9;
  localparam int FINE_W      = 5;
  localparam int POS_W       = 14;
  localparam int NUM_TERMS   = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_DAMPING   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_MARGIN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SIG_BITS-1:0]    sig;
    logic signed [EXP_W-1:0] exp;
  } fp_t;

  typedef struct packed {
    logic [AMT_W-1:0] amt;
    logic             under;
    logic             over;
  } align_ctl_t;

  function automatic fp_t unpack(input logic [63:0] bits);
    fp_t r;
    logic [EXP_FIELD_W-1:0] e;
    e = bits[62:FRAC_BITS];
    if (e == '0) begin
      r.sig = {1'b0, bits[FRAC_BITS-1:0]};
      r.exp = EXP_W'(SUBNORM_EXP);
    end else begin
      r.sig = {1'b1, bits[FRAC_BITS-1:0]};
      r.exp = $signed({1'b0, e}) - EXP_W'(EXP_BIAS);
    end
    return r;
  endfunction

  // finite and not negative, negative zero allowed
  function automatic logic ok_nonneg(input logic [63:0] bits);
    logic [63:0] mag;
    mag = bits & ~SIGN_BIT;
    return (mag < INF_BITS) && !(bits[63] && (mag != '0));
  endfunction

  // place of a product's lsb in the aligner, relative to the threshold's lsb
  function automatic align_ctl_t pos_ctl(input logic signed [EXP_W-1:0] ea,
                                         input logic signed [EXP_W-1:0] eb,
                                         input logic signed [EXP_W-1:0] et);
    align_ctl_t c;
    logic signed [POS_W-1:0] s;
    s = POS_W'(ea) + POS_W'(eb) - POS_W'(et) + POS_W'(WIN_OFS + PROD_W);
    c.under = s < 0;
    c.over  = s > POS_W'(WIN_TOP);
    c.amt   = s[AMT_W-1:0];
    return c;
  endfunction

endpackage

// ----- hdl/ebtc_req_if.sv -----
// ----------------------------------------------------------------------------
// ebtc_req_if
// Request channel: check kind and measured binary64 value.
// ----------------------------------------------------------------------------
interface ebtc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] measured_bits;

  modport source (output valid, output func, output measured_bits, input ready);
  modport sink   (input valid, input func, input measured_bits, output ready);
endinterface

// ----- hdl/ebtc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ebtc_rsp_if
// Result channel: pass and invalid flags.
// ----------------------------------------------------------------------------
interface ebtc_rsp_if;
  logic valid;
  logic ready;
  logic pass;
  logic invalid;

  modport source (output valid, output pass, output invalid, input ready);
  modport sink   (input valid, input pass, input invalid, output ready);
endinterface

// ----- hdl/ebtc_mult.sv -----
// ----------------------------------------------------------------------------
// ebtc_mult
// Two-stage 53x53 significand multiplier, four partials of 27/26-bit halves.
// ----------------------------------------------------------------------------
module ebtc_mult (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ebtc_pkg::SIG_BITS-1:0]  a,
  input  logic [ebtc_pkg::SIG_BITS-1:0]  b,
  output logic [ebtc_pkg::PROD_W-1:0]    p
);
  import ebtc_pkg::*;

  localparam int HI_W = SIG_BITS - HALF_W;

  logic [2*HALF_W-1:0]      pp00;
  logic [HALF_W+HI_W-1:0]   pp01;
  logic [HALF_W+HI_W-1:0]   pp10;
  logic [2*HI_W-1:0]        pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a[HALF_W-1:0] * b[HALF_W-1:0];
      pp01 <= a[HALF_W-1:0] * b[SIG_BITS-1:HALF_W];
      pp10 <= a[SIG_BITS-1:HALF_W] * b[HALF_W-1:0];
      pp11 <= a[SIG_BITS-1:HALF_W] * b[SIG_BITS-1:HALF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PROD_W'(pp11) << (2 * HALF_W))
         + ((PROD_W'(pp01) + PROD_W'(pp10)) << HALF_W)
         + PROD_W'(pp00);
    end
  end

endmodule

// ----- hdl/ebtc_align.sv -----
// ----------------------------------------------------------------------------
// ebtc_align
// Two-stage aligner: places a product into the fixed-point window and
// reports the bits that fall below it (sticky) and above it (overflow).
// ----------------------------------------------------------------------------
module ebtc_align (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ebtc_pkg::PROD_W-1:0]   sig,
  input  ebtc_pkg::align_ctl_t          ctl,
  output logic [ebtc_pkg::WIN_W-1:0]    win,
  output logic                          sticky,
  output logic                          ovf
);
  import ebtc_pkg::*;

  logic [SHIFT_W-1:0] coarse;
  logic [FINE_W-1:0]  fine;
  logic               under;
  logic               over;
  logic               nz;
  logic [SHIFT_W-1:0] z;

  // coarse shift by multiples of 32
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.under || ctl.over) begin
        coarse <= '0;
      end else begin
        coarse <= SHIFT_W'(sig) << {ctl.amt[AMT_W-1:FINE_W], FINE_W'(0)};
      end
      fine  <= ctl.amt[FINE_W-1:0];
      under <= ctl.under;
      over  <= ctl.over;
      nz    <= |sig;
    end
  end

  assign z = coarse << fine;

  always_ff @(posedge clk) begin
    if (en) begin
      win    <= z[WIN_TOP-1:PROD_W];
      sticky <= (under && nz) || (|z[PROD_W-1:0]);
      ovf    <= (over && nz) || (|z[SHIFT_W-1:WIN_TOP]);
    end
  end

endmodule

// ----- hdl/exact_binary64_threshold_check.sv -----
// ----------------------------------------------------------------------------
// exact_binary64_threshold_check
// Exact, unrounded comparison of a sum of binary64 values and products
// against a binary64 threshold, for the prefilter and residual checks.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, measured_bits
//   rsp      out  valid/ready    pass, invalid
//   apb      in   psel/penable   paddr, pwdata, prdata (64-bit registers)
//
// one transaction per cycle while the result side does not stall
// seven register stages: capture and decode, two multiplier stages, two
// aligner stages, window sum, compare
// reset clears the configuration registers and all stage valid bits
// a stalled result freezes every stage, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module exact_binary64_threshold_check (
  input  logic                          clk,
  input  logic                          rst,
  ebtc_req_if.sink                      req,
  ebtc_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ebtc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ebtc_pkg::DATA_W-1:0]   pwdata,
  output logic [ebtc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ebtc_pkg::*;

  logic [63:0] damping_bits;
  logic [63:0] threshold_bits;
  logic [63:0] margin_bits;

  logic        adv;
  logic [7:1]  vld;

  logic        func1;
  logic [63:0] meas1;

  fp_t         fa;
  fp_t         ft;
  fp_t         fm;
  fp_t         fv;
  logic        bad1;
  logic [SIG_BITS-1:0]     op1a;
  logic signed [EXP_W-1:0] e1a;
  logic [PROD_W-1:0]       msig1;
  align_ctl_t              ctl1 [NUM_TERMS];
  align_ctl_t              ctl2 [NUM_TERMS];
  align_ctl_t              ctl3 [NUM_TERMS];
  logic [PROD_W-1:0]       msig2;
  logic [PROD_W-1:0]       msig3;
  logic [6:2]              inv_d;

  logic [PROD_W-1:0]       prod1;
  logic [PROD_W-1:0]       prod3;
  logic [PROD_W-1:0]       asig [NUM_TERMS];
  logic [WIN_W-1:0]        win [NUM_TERMS];
  logic [NUM_TERMS-1:0]    sticky;
  logic [NUM_TERMS-1:0]    ovf;

  logic [SUM_W-1:0]        sum6;
  logic                    ovf6;
  logic [SUM_W-1:0]        eta_win;
  fp_t                     ft_live;
  logic                    pass7;
  logic                    inv7;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_bits   <= '0;
      threshold_bits <= '0;
      margin_bits    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[ADDR_W-1:3])
        REG_DAMPING:   damping_bits   <= pwdata;
        REG_THRESHOLD: threshold_bits <= pwdata;
        REG_MARGIN:    margin_bits    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:3])
      REG_DAMPING:   prdata = damping_bits;
      REG_THRESHOLD: prdata = threshold_bits;
      REG_MARGIN:    prdata = margin_bits;
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  assign adv       = !vld[7] || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:1], req.valid};
    end
  end

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (adv) begin
      func1 <= req.func;
      meas1 <= req.measured_bits;
    end
  end

  // decode, operand checks and window positions
  always_comb begin
    fa = unpack(damping_bits);
    ft = unpack(threshold_bits);
    fm = unpack(margin_bits);
    fv = unpack(meas1);
    bad1 = !ok_nonneg(meas1)
        || damping_bits[63] || (damping_bits == '0) || (damping_bits >= ONE_BITS)
        || threshold_bits[63] || (threshold_bits == '0)
        || (threshold_bits >= INF_BITS)
        || (func1 && !ok_nonneg(margin_bits));
    op1a  = func1 ? SIG_BITS'(1) : fa.sig;
    e1a   = func1 ? EXP_W'(0) : fa.exp;
    msig1 = func1 ? PROD_W'(fm.sig) : '0;
    ctl1[0] = pos_ctl(e1a, fv.exp, ft.exp);
    ctl1[1] = pos_ctl(fm.exp, EXP_W'(0), ft.exp);
    ctl1[2] = pos_ctl(fa.exp, ft.exp, ft.exp);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl2  <= ctl1;
      ctl3  <= ctl2;
      msig2 <= msig1;
      msig3 <= msig2;
      inv_d <= {inv_d[5:2], bad1};
    end
  end

  ebtc_mult u_mult_meas (
    .clk (clk),
    .en  (adv),
    .a   (op1a),
    .b   (fv.sig),
    .p   (prod1)
  );

  ebtc_mult u_mult_eta (
    .clk (clk),
    .en  (adv),
    .a   (fa.sig),
    .b   (ft.sig),
    .p   (prod3)
  );

  assign asig[0] = prod1;
  assign asig[1] = msig3;
  assign asig[2] = prod3;

  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_align
    ebtc_align u_align (
      .clk    (clk),
      .en     (adv),
      .sig    (asig[i]),
      .ctl    (ctl3[i]),
      .win    (win[i]),
      .sticky (sticky[i]),
      .ovf    (ovf[i])
    );
  end

  // stage 6: window sum, any bit below the window counts as one unit
  always_ff @(posedge clk) begin
    if (adv) begin
      sum6 <= SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]) + SUM_W'(|sticky);
      ovf6 <= |ovf;
    end
  end

  // stage 7: compare against the threshold in the same window
  assign ft_live = unpack(threshold_bits);
  assign eta_win = SUM_W'(ft_live.sig) << WIN_OFS;

  always_ff @(posedge clk) begin
    if (adv) begin
      pass7 <= !inv_d[6] && !ovf6 && (sum6 <= eta_win);
      inv7  <= inv_d[6];
    end
  end

  assign rsp.valid   = vld[7];
  assign rsp.pass    = pass7;
  assign rsp.invalid = inv7;

`ifndef NO_ASSERTIONS
  a_pass_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.pass && rsp.invalid))
    else $error("pass and invalid both set");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while result is stalled");

  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !rsp.valid)
    else $error("result valid right after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> vld[1])
    else $error("accepted transaction not in first stage");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the exact binary64 threshold check. Requests are sent with
// random gaps while the result side stalls at random; one phase has neither.
// An internal predictor evaluates each check with wide integer sums, so the
// answer is exact. Each result is compared in order with the predicted flags.
// Register settings change only between phases, once the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import ebtc_pkg::*;

  localparam int ACC_W = 4224;
  localparam int SCALE = 2148;
  localparam int DRAIN_CYCLES = 12;
  localparam bit FUNC_PREFILTER = 1'b0;
  localparam bit FUNC_RESIDUAL  = 1'b1;

  typedef bit [ACC_W-1:0] wide_t;
  typedef struct packed {
    bit pass;
    bit invalid;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  ebtc_req_if req ();
  ebtc_rsp_if rsp ();

  exact_binary64_threshold_check uut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  bit [63:0] alpha_reg, eta_reg, margin_reg;
  verdict_t expected_verdicts[$];
  bit gaps_on = 1'b1;
  int errors, items_sent, results_seen, passes_seen, invalids_seen, phases_run;

  function automatic void split_fp(input bit [63:0] b, output bit [52:0] s, output int e);
    if (b[62:52] == '0) begin
      s = {1'b0, b[51:0]};
      e = SUBNORM_EXP;
    end else begin
      s = {1'b1, b[51:0]};
      e = int'(b[62:52]) - EXP_BIAS;
    end
  endfunction

  function automatic wide_t exact_value(input bit [63:0] b);
    bit [52:0] s;
    int e;
    split_fp(b, s, e);
    return wide_t'(s) << (e + SCALE);
  endfunction

  function automatic wide_t exact_product(input bit [63:0] x, input bit [63:0] y);
    bit [52:0] sx, sy;
    bit [105:0] p;
    int ex, ey;
    split_fp(x, sx, ex);
    split_fp(y, sy, ey);
    p = {53'b0, sx} * {53'b0, sy};
    return wide_t'(p) << (ex + ey + SCALE);
  endfunction

  function automatic bit finite_nonneg(input bit [63:0] b);
    bit [63:0] mag;
    mag = b & ~SIGN_BIT;
    return (mag < INF_BITS) && !(b[63] && mag != '0);
  endfunction

  function automatic verdict_t predict_check(input bit f, input bit [63:0] meas);
    verdict_t v;
    wide_t lhs;
    bit ok;
    ok = finite_nonneg(meas);
    if (alpha_reg[63] || alpha_reg == '0 || alpha_reg >= ONE_BITS) ok = 0;
    if (eta_reg[63] || eta_reg == '0 || eta_reg >= INF_BITS) ok = 0;
    if (f == FUNC_RESIDUAL && !finite_nonneg(margin_reg)) ok = 0;
    if (!ok) begin
      v.pass = 0;
      v.invalid = 1;
      return v;
    end
    if (f == FUNC_PREFILTER)
      lhs = exact_product(meas, alpha_reg) + exact_product(eta_reg, alpha_reg);
    else
      lhs = exact_value(meas) + exact_value(margin_reg) + exact_product(alpha_reg, eta_reg);
    v.pass = lhs <= exact_value(eta_reg);
    v.invalid = 0;
    return v;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [63:0] rand_fp();
    bit [63:0] r;
    r = rand64();
    case ($urandom_range(5))
      0: ;
      1: r[63] = 1'b0;
      2: r[63:52] = '0;
      3: r = {r[63], 63'b0};
      4: r[62:52] = '1;
      default: r = {1'b0, 11'($urandom_range(1063, 983)), r[51:0]};
    endcase
    return r;
  endfunction

  function automatic bit [63:0] near_boundary(input bit f);
    real a, t, m, r;
    a = $bitstoreal(alpha_reg);
    t = $bitstoreal(eta_reg);
    m = $bitstoreal(margin_reg);
    if (f == FUNC_RESIDUAL) r = t * (1.0 - a) - m;
    else if (a > 0.0) r = t * (1.0 - a) / a;
    else r = 1.0;
    return $realtobits(r) + 64'($signed($urandom_range(8)) - 4);
  endfunction

  // config write, two-phase bus cycle
  task automatic write_reg(input reg_idx_t idx, input bit [63:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx) << 3; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DAMPING: alpha_reg = v;
      REG_THRESHOLD: eta_reg = v;
      default: margin_reg = v;
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 0;
    wait (expected_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input bit [63:0] a, input bit [63:0] t, input bit [63:0] m);
    drain();
    write_reg(REG_DAMPING, a);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_MARGIN, m);
    phases_run++;
  endtask

  task automatic send_check(input bit f, input bit [63:0] meas);
    int n;
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 30) begin
      n = $urandom_range(2, 1);
      req.valid <= 0;
      repeat (n) @(negedge clk);
    end
    req.valid <= 1;
    req.func <= f;
    req.measured_bits <= meas;
    do @(posedge clk); while (!req.ready);
    expected_verdicts.push_back(predict_check(f, meas));
    items_sent++;
  endtask

  always @(negedge clk)
    rsp.ready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      passes_seen += rsp.pass;
      invalids_seen += rsp.invalid;
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (rsp.pass !== exp_v.pass) begin
          $error("pass: expected %0d actual %0d", exp_v.pass, rsp.pass);
          errors++;
        end
        if (rsp.invalid !== exp_v.invalid) begin
          $error("invalid: expected %0d actual %0d", exp_v.invalid, rsp.invalid);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    set_config(64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FD0_0000_0000_0000);
    send_check(FUNC_PREFILTER, 64'h3FF0_0000_0000_0000);
    send_check(FUNC_PREFILTER, 64'h3FF0_0000_0000_0001);
    send_check(FUNC_PREFILTER, 64'h0);
    send_check(FUNC_PREFILTER, SIGN_BIT);
    send_check(FUNC_RESIDUAL, 64'h3FD0_0000_0000_0000);
    send_check(FUNC_RESIDUAL, 64'h3FD0_0000_0000_0001);
    send_check(FUNC_RESIDUAL, 64'h7FEF_FFFF_FFFF_FFFF);
    send_check(FUNC_RESIDUAL, 64'h1);
    send_check(FUNC_PREFILTER, 64'h000F_FFFF_FFFF_FFFF);
    send_check(FUNC_PREFILTER, 64'h7FF8_0000_0000_0000);
    send_check(FUNC_RESIDUAL, INF_BITS);
    send_check(FUNC_RESIDUAL, 64'hFFF0_0000_0000_0000);
    send_check(FUNC_PREFILTER, 64'hBFF0_0000_0000_0000);
    send_check(FUNC_RESIDUAL, '1);
  endtask

  task automatic test_config_edges();
    set_config(64'h0, 64'h3FF0_0000_0000_0000, 64'h0);
    send_check(FUNC_RESIDUAL, 64'h0);
    set_config(ONE_BITS, 64'h3FF0_0000_0000_0000, 64'h0);
    send_check(FUNC_PREFILTER, 64'h0);
    set_config(64'h3FEF_FFFF_FFFF_FFFF, 64'h1, SIGN_BIT);
    send_check(FUNC_RESIDUAL, 64'h0);
    send_check(FUNC_PREFILTER, 64'h1);
    set_config(64'h1, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
    send_check(FUNC_RESIDUAL, 64'h0);
    send_check(FUNC_PREFILTER, 64'h7FEF_FFFF_FFFF_FFFF);
    set_config(64'h3FE0_0000_0000_0000, SIGN_BIT, 64'h0);
    send_check(FUNC_PREFILTER, 64'h0);
    set_config(64'h3FE0_0000_0000_0000, INF_BITS, 64'h7FF8_0000_0000_0001);
    send_check(FUNC_PREFILTER, 64'h0);
    set_config(64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001);
    send_check(FUNC_RESIDUAL, 64'h0);
    send_check(FUNC_PREFILTER, 64'h0);
  endtask

  task automatic test_random();
    bit [63:0] a, t, m, meas, r;
    bit f;
    for (int ph = 0; ph < 12; ph++) begin
      r = rand64();
      a = {2'b00, 10'($urandom_range(1022, 0)), r[51:0]};
      r = rand64();
      t = {1'b0, 11'($urandom_range(1100, 900)), r[51:0]};
      r = rand64();
      m = {2'b00, 10'($urandom_range(1022, 0)), r[51:0]};
      if (ph % 4 == 3) a = rand_fp();
      if (ph % 5 == 4) t = rand_fp();
      if (ph % 3 == 2) m = rand_fp();
      if (ph == 0) begin
        a = 64'h1; t = 64'h7FEF_FFFF_FFFF_FFFF; m = 64'h7FEF_FFFF_FFFF_FFFF;
      end
      if (ph == 1) begin
        a = 64'h3FEF_FFFF_FFFF_FFFF; t = 64'h1; m = 64'h0;
      end
      set_config(a, t, m);
      gaps_on = (ph != 2);
      for (int i = 0; i < 125; i++) begin
        f = 1'($urandom_range(1));
        case ($urandom_range(19))
          0, 1, 2: meas = rand_fp();
          3, 4, 5: meas = rand64();
          default: meas = near_boundary(f);
        endcase
        send_check(f, meas);
      end
    end
    gaps_on = 1;
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req.valid = 0; req.func = 0; req.measured_bits = '0;
    rsp.ready = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_config_edges();
    test_random();
    drain();
    $display("checked %0d results from %0d requests over %0d register settings",
             results_seen, items_sent, phases_run);
    $display("%0d passed the threshold, %0d flagged invalid", passes_seen, invalids_seen);
    if (errors == 0 && expected_verdicts.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
